@@ rtl/core/ptrm_pkg.sv @@
// ----------------------------------------------------------------------------
// ptrm_pkg
// Shared types and constants of the priority tile reservation merge unit.
// ----------------------------------------------------------------------------
package ptrm_pkg;

  localparam int MAX_NODES = 31;
  localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int INDEX_W   = 6;
  localparam int VALUE_W   = 16;

  typedef enum logic {
    KIND_PRIO = 1'b0,
    KIND_TILE = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic               en;
    logic [NODE_W-1:0]  addr;
    logic [VALUE_W-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic [VALUE_W-1:0] prio_a;
    logic [VALUE_W-1:0] prio_b;
  } prio_rd_t;

endpackage

@@ rtl/core/priority_tile_reservation_merge_unit.sv @@
// ----------------------------------------------------------------------------
// priority_tile_reservation_merge_unit
// Merges node priority pairs into a table and resolves tile owner pairs.
// ----------------------------------------------------------------------------
// Accepts one request per clock unless stalled and returns one result per
// request. Requests pass the stage-one registers, beside the two registered
// read ports of the priority table RAM, then the output registers. The table
// is written at acceptance, so a tile request right after a priority request
// sees the new entry. Table entries read as zero after reset until written.
module priority_tile_reservation_merge_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [ptrm_pkg::INDEX_W-1:0]  in_item_index,
  input  logic [ptrm_pkg::VALUE_W-1:0]  in_rx_value,
  input  logic [ptrm_pkg::VALUE_W-1:0]  in_tx_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic [ptrm_pkg::INDEX_W-1:0]  out_result_index,
  output logic [ptrm_pkg::VALUE_W-1:0]  out_merged_value
);

  logic                         in_accept;
  ptrm_pkg::tbl_wr_t            tbl_wr;
  ptrm_pkg::prio_rd_t           tbl_rd;

  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  ptrm_pkg::req_kind_t          s1_kind_r;
  logic [ptrm_pkg::INDEX_W-1:0] s1_index_r;
  logic [ptrm_pkg::VALUE_W-1:0] s1_rx_r;
  logic [ptrm_pkg::VALUE_W-1:0] s1_tx_r;

  logic                         out_load;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  ptrm_pkg::req_kind_t          out_kind_r;
  logic [ptrm_pkg::INDEX_W-1:0] out_index_r;
  logic [ptrm_pkg::VALUE_W-1:0] out_value_r;
  logic [ptrm_pkg::VALUE_W-1:0] merged_nxt;

  assign out_load  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !out_load;
  assign in_accept = in_valid && !in_stall;

  assign tbl_wr.en   = in_accept && (in_req_type == ptrm_pkg::KIND_PRIO) &&
                       ({{(32 - ptrm_pkg::INDEX_W){1'b0}}, in_item_index} <
                        32'(ptrm_pkg::MAX_NODES));
  assign tbl_wr.addr = ptrm_pkg::NODE_W'(in_item_index);
  assign tbl_wr.data = in_rx_value | in_tx_value;

  ptrm_prio_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_en   (in_accept),
    .owner_a (in_rx_value),
    .owner_b (in_tx_value),
    .rd      (tbl_rd)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    unique case (s1_kind_r)
      ptrm_pkg::KIND_PRIO: merged_nxt = s1_rx_r | s1_tx_r;
      ptrm_pkg::KIND_TILE: begin
        priority if (tbl_rd.prio_a == tbl_rd.prio_b) begin
          merged_nxt = (s1_tx_r >= s1_rx_r) ? s1_tx_r : s1_rx_r;
        end else if (tbl_rd.prio_a > tbl_rd.prio_b) begin
          merged_nxt = s1_rx_r;
        end else begin
          merged_nxt = s1_tx_r;
        end
      end
      default: merged_nxt = s1_rx_r | s1_tx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r  <= ptrm_pkg::req_kind_t'(in_req_type);
      s1_index_r <= in_item_index;
      s1_rx_r    <= in_rx_value;
      s1_tx_r    <= in_tx_value;
    end
    if (out_load) begin
      out_kind_r  <= s1_kind_r;
      out_index_r <= s1_index_r;
      out_value_r <= merged_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_index = out_index_r;
  assign out_merged_value = out_value_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while the pipeline has room");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> (s1_valid_r && out_valid_r))
    else $error("request dropped under output stall");

  a_tile_winner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (s1_kind_r == ptrm_pkg::KIND_TILE)) |=>
      ((out_merged_value == $past(s1_rx_r)) || (out_merged_value == $past(s1_tx_r))))
    else $error("tile result is neither owner");

endmodule

@@ rtl/core/ptrm_ram.sv @@
// ----------------------------------------------------------------------------
// ptrm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module ptrm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                           rdata_a,
  output logic [WIDTH-1:0]                           rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

@@ rtl/core/ptrm_prio_table.sv @@
// ----------------------------------------------------------------------------
// ptrm_prio_table
// Node priority table: RAM plus per-entry valid bits; owner lookup for two ids.
// ----------------------------------------------------------------------------
module ptrm_prio_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptrm_pkg::tbl_wr_t           wr,
  input  logic                        rd_en,
  input  logic [ptrm_pkg::VALUE_W-1:0] owner_a,
  input  logic [ptrm_pkg::VALUE_W-1:0] owner_b,
  output ptrm_pkg::prio_rd_t          rd
);

  logic [ptrm_pkg::MAX_NODES-1:0] valid_r;
  logic [ptrm_pkg::MAX_NODES-1:0] valid_nxt;
  logic                           hit_a;
  logic                           hit_b;
  logic [ptrm_pkg::NODE_W-1:0]    addr_a;
  logic [ptrm_pkg::NODE_W-1:0]    addr_b;
  logic                           ok_a_r;
  logic                           ok_b_r;
  logic [ptrm_pkg::VALUE_W-1:0]   q_a;
  logic [ptrm_pkg::VALUE_W-1:0]   q_b;

  assign hit_a = (owner_a != '0) &&
                 (owner_a <= ptrm_pkg::VALUE_W'(ptrm_pkg::MAX_NODES));
  assign hit_b = (owner_b != '0) &&
                 (owner_b <= ptrm_pkg::VALUE_W'(ptrm_pkg::MAX_NODES));
  assign addr_a = hit_a ? ptrm_pkg::NODE_W'(owner_a - 16'd1) : '0;
  assign addr_b = hit_b ? ptrm_pkg::NODE_W'(owner_b - 16'd1) : '0;

  always_comb begin
    valid_nxt = valid_r;
    if (wr.en) begin
      valid_nxt[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ok_a_r <= hit_a && valid_r[addr_a];
      ok_b_r <= hit_b && valid_r[addr_b];
    end
  end

  ptrm_ram #(
    .WIDTH (ptrm_pkg::VALUE_W),
    .DEPTH (ptrm_pkg::MAX_NODES)
  ) u_ram (
    .clk     (clk),
    .we      (wr.en),
    .waddr   (wr.addr),
    .wdata   (wr.data),
    .re      (rd_en),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (q_a),
    .rdata_b (q_b)
  );

  assign rd.prio_a = ok_a_r ? q_a : '0;
  assign rd.prio_b = ok_b_r ? q_b : '0;

endmodule

@@ bench/priority_tile_reservation_merge_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_tile_reservation_merge_unit_tb
// Sends node priority and tile owner requests through the merge unit with
// random input gaps and output stalls. A scoreboard keeps its own copy of the
// priority table, predicts every result and checks the results in order.
// ----------------------------------------------------------------------------
module priority_tile_reservation_merge_unit_tb;
  import ptrm_pkg::*;

  localparam int NUM_REQUESTS = 1950;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    req_kind_t          kind;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } merge_result_t;

  class merge_scoreboard;
    logic [VALUE_W-1:0] node_priority [MAX_NODES];
    merge_result_t      pending_results [$];
    int                 mismatches;

    function new();
      foreach (node_priority[k]) node_priority[k] = '0;
      mismatches = 0;
    endfunction

    function logic [VALUE_W-1:0] owner_priority(logic [VALUE_W-1:0] owner);
      if (owner == 0 || owner > MAX_NODES) return '0;
      return node_priority[owner - 1];
    endfunction

    function void note_request(req_kind_t kind, logic [INDEX_W-1:0] index,
                               logic [VALUE_W-1:0] rx, logic [VALUE_W-1:0] tx);
      merge_result_t      r;
      logic [VALUE_W-1:0] rx_prio;
      logic [VALUE_W-1:0] tx_prio;
      r.kind  = kind;
      r.index = index;
      if (kind == KIND_PRIO) begin
        r.value = rx | tx;
        if (index < MAX_NODES) node_priority[index] = r.value;
      end else begin
        rx_prio = owner_priority(rx);
        tx_prio = owner_priority(tx);
        if (rx_prio == tx_prio) r.value = (tx >= rx) ? tx : rx;
        else if (rx_prio > tx_prio) r.value = rx;
        else r.value = tx;
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(req_kind_t kind, logic [INDEX_W-1:0] index,
                               logic [VALUE_W-1:0] value);
      merge_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d index %0d value %h",
                 $time, kind, index, value);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (kind != want.kind) begin
        $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, kind);
        mismatches++;
      end
      if (index !== want.index) begin
        $display("%0t: result_index expected %0d actual %0d", $time, want.index, index);
        mismatches++;
      end
      if (value !== want.value) begin
        $display("%0t: merged_value expected %h actual %h", $time, want.value, value);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic               in_req_type      = 1'b0;
  logic [INDEX_W-1:0] in_item_index    = '0;
  logic [VALUE_W-1:0] in_rx_value      = '0;
  logic [VALUE_W-1:0] in_tx_value      = '0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic               out_result_kind;
  logic [INDEX_W-1:0] out_result_index;
  logic [VALUE_W-1:0] out_merged_value;

  bit                 quiet            = 1'b0;
  int                 requests_sent    = 0;
  int                 cycles           = 0;
  merge_scoreboard    sb               = new();

  priority_tile_reservation_merge_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_item_index    (in_item_index),
    .in_rx_value      (in_rx_value),
    .in_tx_value      (in_tx_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_result_index (out_result_index),
    .out_merged_value (out_merged_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 19);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(req_kind_t'(out_result_kind), out_result_index, out_merged_value);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(req_kind_t kind, logic [INDEX_W-1:0] index,
                              logic [VALUE_W-1:0] rx, logic [VALUE_W-1:0] tx);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_item_index <= index;
    in_rx_value   <= rx;
    in_tx_value   <= tx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(kind, index, rx, tx);
    requests_sent++;
  endtask

  function automatic logic [VALUE_W-1:0] random_priority();
    case ($urandom_range(3))
      0: return VALUE_W'($urandom_range(3));
      1: return 16'h1 << $urandom_range(VALUE_W - 1);
      2: return VALUE_W'($urandom_range(16'hFFFF));
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] random_owner();
    case ($urandom_range(19))
      0, 1: return VALUE_W'($urandom_range(255, MAX_NODES + 1));
      2: return VALUE_W'($urandom_range(16'hFFFF));
      default: return VALUE_W'($urandom_range(MAX_NODES));
    endcase
  endfunction

  initial begin
    int n_prio;
    int n_tile;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    quiet <= 1'b1;
    @(posedge clk);

    send_request(KIND_PRIO, 0,  16'h0000, 16'h0000);
    send_request(KIND_PRIO, 30, 16'hFFFF, 16'h0000);
    send_request(KIND_PRIO, 0,  16'h0001, 16'h8000);
    send_request(KIND_PRIO, 1,  16'h0F0F, 16'h0000);
    send_request(KIND_PRIO, 31, 16'hAAAA, 16'h5555);
    send_request(KIND_PRIO, 63, 16'hFFFF, 16'hFFFF);
    send_request(KIND_TILE, 0,  16'd0,    16'd0);
    send_request(KIND_TILE, 63, 16'd0,    16'd31);
    send_request(KIND_TILE, 1,  16'd31,   16'd0);
    send_request(KIND_TILE, 2,  16'd1,    16'd2);
    send_request(KIND_TILE, 3,  16'd2,    16'd1);
    send_request(KIND_TILE, 4,  16'd32,   16'd0);
    send_request(KIND_TILE, 5,  16'hFFFF, 16'd3);
    send_request(KIND_TILE, 6,  16'd5,    16'd5);
    send_request(KIND_TILE, 7,  16'd31,   16'd32);
    send_request(KIND_PRIO, 2,  16'h0000, 16'h0000);
    send_request(KIND_TILE, 8,  16'd3,    16'd40);
    send_request(KIND_PRIO, 4,  16'h1234, 16'h0000);
    send_request(KIND_TILE, 9,  16'd5,    16'd0);
    send_request(KIND_PRIO, 4,  16'h0000, 16'h0000);
    send_request(KIND_TILE, 10, 16'd5,    16'd6);
    send_request(KIND_PRIO, 30, 16'h0000, 16'h0000);
    send_request(KIND_TILE, 11, 16'd31,   16'd1);

    while (requests_sent < NUM_REQUESTS) begin
      quiet <= (requests_sent >= 900 && requests_sent < 1200);
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_request(req_kind_t'($urandom_range(1)), INDEX_W'($urandom_range(63)),
                       VALUE_W'($urandom_range(16'hFFFF)),
                       VALUE_W'($urandom_range(16'hFFFF)));
        end
      end else begin
        n_prio = $urandom_range(1, 40);
        n_tile = $urandom_range(1, 60);
        repeat (n_prio) begin
          send_request(KIND_PRIO,
                       ($urandom_range(9) == 0) ? INDEX_W'($urandom_range(63, MAX_NODES))
                                                : INDEX_W'($urandom_range(MAX_NODES - 1)),
                       random_priority(), random_priority());
        end
        repeat (n_tile) begin
          send_request(KIND_TILE, INDEX_W'($urandom_range(63)),
                       random_owner(), random_owner());
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ptrm_pkg.sv
rtl/core/ptrm_ram.sv
rtl/core/ptrm_prio_table.sv
rtl/core/priority_tile_reservation_merge_unit.sv
bench/priority_tile_reservation_merge_unit_tb.sv
